@@ hdl/lir_pkg.sv @@
// shared types and constants for the linear interpolation resampler
// no dependencies; imported by lir_ctrl, lir_dp and the top level
`timescale 1ns / 1ps
`default_nettype none

package lir_pkg;

    // configuration port
    localparam int RATIO_W    = 24;
    localparam int CHAN_W     = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_RATIO    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 1'b1;

    localparam logic [CHAN_W-1:0] CHAN_MONO  = 2'd1;
    localparam logic [CHAN_W-1:0] CHAN_RESET = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic first;
        logic skip;
        logic mul;
        logic emit_interp;
        logic emit_hold;
        logic clear;
    } lir_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic have_prior;
        logic off_lt_one;
        logic end_frame;
        logic slot_free;
        logic next_ge_one;
    } lir_sts_t;

endpackage

`default_nettype wire

@@ hdl/lir_ctrl.sv @@
// sequencing state machine for the resampler
// depends on lir_pkg for the command and status structs
`timescale 1ns / 1ps
`default_nettype none

module lir_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  lir_pkg::lir_sts_t      sts,
    output lir_pkg::lir_cmd_t      cmd
);
    import lir_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_START = 6'b000010,
        S_MUL   = 6'b000100,
        S_EMIT  = 6'b001000,
        S_TAIL  = 6'b010000,
        S_HOLD  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_START;
                end
            end
            S_START:
            begin
                if (!sts.have_prior)
                begin
                    cmd.first  = 1'b1;
                    state_next = S_TAIL;
                end
                else if (sts.off_lt_one)
                begin
                    state_next = S_MUL;
                end
                else
                begin
                    // position already past this frame: no interpolated word
                    cmd.skip   = 1'b1;
                    state_next = S_TAIL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (sts.slot_free)
                begin
                    cmd.emit_interp = 1'b1;
                    state_next      = sts.next_ge_one ? S_TAIL : S_MUL;
                end
            end
            S_TAIL:
            begin
                if (!sts.end_frame)
                begin
                    state_next = S_IDLE;
                end
                else if (sts.off_lt_one)
                begin
                    state_next = S_HOLD;
                end
                else
                begin
                    cmd.clear  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_HOLD:
            begin
                if (sts.slot_free)
                begin
                    cmd.emit_hold = 1'b1;
                    if (sts.next_ge_one)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/lir_dp.sv @@
// datapath: config registers, frame store, position, multipliers, output register
// depends on lir_pkg; driven by lir_ctrl commands
`timescale 1ns / 1ps
`default_nettype none

module lir_dp #(
    parameter int SAMPLE_BITS = 24,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write,
    input  wire logic [lir_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [lir_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic signed [SAMPLE_BITS-1:0]     left_sample,
    input  wire logic signed [SAMPLE_BITS-1:0]     right_sample,
    input  wire logic                              end_of_clip,
    input  lir_pkg::lir_cmd_t                      cmd,
    output lir_pkg::lir_sts_t                      sts,
    input  wire logic                              out_ready,
    output logic                                   out_valid,
    output logic signed [SAMPLE_BITS-1:0]          left_out,
    output logic signed [SAMPLE_BITS-1:0]          right_out,
    output logic                                   run_last,
    output logic                                   clip_done
);
    import lir_pkg::*;

    localparam int OFF_W  = ((FRAC_BITS + 1 > RATIO_W) ? FRAC_BITS + 1 : RATIO_W) + 1;
    localparam int PROD_W = SAMPLE_BITS + FRAC_BITS + 2;

    localparam logic [OFF_W-1:0]   ONE_OFF  = OFF_W'(64'd1 << FRAC_BITS);
    localparam logic [OFF_W-1:0]   TWO_OFF  = OFF_W'(64'd1 << (FRAC_BITS + 1));
    localparam logic [RATIO_W-1:0] MIN_STEP = RATIO_W'(64'd1 << (FRAC_BITS - 5));
    localparam logic [RATIO_W-1:0] RATIO_RESET = (FRAC_BITS < RATIO_W) ?
        RATIO_W'(64'd1 << FRAC_BITS) : {RATIO_W{1'b1}};

    logic [RATIO_W-1:0]            ratio_reg;
    logic [CHAN_W-1:0]             chan_reg;
    logic [OFF_W-1:0]              offset_reg;
    logic [OFF_W-1:0]              offset_next;
    logic                          have_prior_reg;
    logic                          have_prior_next;
    logic                          end_reg;
    logic signed [SAMPLE_BITS-1:0] prior_l_reg;
    logic signed [SAMPLE_BITS-1:0] prior_r_reg;
    logic signed [SAMPLE_BITS-1:0] cur_l_reg;
    logic signed [SAMPLE_BITS-1:0] cur_r_reg;
    logic signed [PROD_W-1:0]      prod_l_reg;
    logic signed [PROD_W-1:0]      prod_r_reg;
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] left_out_reg;
    logic signed [SAMPLE_BITS-1:0] right_out_reg;
    logic                          run_last_reg;
    logic                          clip_done_reg;

    logic [RATIO_W-1:0]            step;
    logic [OFF_W-1:0]              next_off;
    logic                          next_ge_one;
    logic                          next_ge_two;
    logic                          off_lt_one;
    logic                          slot_free;
    logic                          mono;
    logic                          emit;
    logic                          prior_load;
    logic signed [FRAC_BITS:0]     frac_s;
    logic signed [SAMPLE_BITS:0]   diff_l;
    logic signed [SAMPLE_BITS:0]   diff_r;
    logic signed [PROD_W-1:0]      sum_l;
    logic signed [PROD_W-1:0]      sum_r;
    logic signed [SAMPLE_BITS-1:0] word_l;
    logic signed [SAMPLE_BITS-1:0] word_r;
    logic                          word_last;
    logic                          word_done;

    // ratios below 1/32 step as 1/32
    assign step        = (ratio_reg < MIN_STEP) ? MIN_STEP : ratio_reg;
    assign next_off    = offset_reg + OFF_W'(step);
    assign next_ge_one = (next_off >= ONE_OFF);
    assign next_ge_two = (next_off >= TWO_OFF);
    assign off_lt_one  = (offset_reg < ONE_OFF);
    assign slot_free   = !out_valid_reg || out_ready;
    assign mono        = (chan_reg == CHAN_MONO);
    assign emit        = cmd.emit_interp || cmd.emit_hold;

    assign sts.have_prior  = have_prior_reg;
    assign sts.off_lt_one  = off_lt_one;
    assign sts.end_frame   = end_reg;
    assign sts.slot_free   = slot_free;
    assign sts.next_ge_one = next_ge_one;

    assign frac_s = signed'({1'b0, offset_reg[FRAC_BITS-1:0]});
    assign diff_l = signed'({cur_l_reg[SAMPLE_BITS-1], cur_l_reg})
                  - signed'({prior_l_reg[SAMPLE_BITS-1], prior_l_reg});
    assign diff_r = signed'({cur_r_reg[SAMPLE_BITS-1], cur_r_reg})
                  - signed'({prior_r_reg[SAMPLE_BITS-1], prior_r_reg});

    // a + ((b - a) * frac >>> frac_bits), always between a and b
    assign sum_l = PROD_W'(prior_l_reg) + (prod_l_reg >>> FRAC_BITS);
    assign sum_r = PROD_W'(prior_r_reg) + (prod_r_reg >>> FRAC_BITS);

    always_comb
    begin
        if (cmd.emit_interp)
        begin
            word_l    = sum_l[SAMPLE_BITS-1:0];
            word_r    = sum_r[SAMPLE_BITS-1:0];
            // last of the run once the position leaves the frame, unless an end frame has hold words
            word_last = next_ge_one && (!end_reg || next_ge_two);
            word_done = next_ge_one && end_reg && next_ge_two;
        end
        else
        begin
            word_l    = cur_l_reg;
            word_r    = cur_r_reg;
            word_last = next_ge_one;
            word_done = next_ge_one;
        end
    end

    always_comb
    begin
        offset_next     = offset_reg;
        have_prior_next = have_prior_reg;
        prior_load      = 1'b0;
        if (cmd.first)
        begin
            offset_next     = '0;
            have_prior_next = 1'b1;
            prior_load      = 1'b1;
        end
        else if (cmd.skip)
        begin
            offset_next = offset_reg - ONE_OFF;
            prior_load  = 1'b1;
        end
        else if (cmd.emit_interp)
        begin
            if (next_ge_one)
            begin
                offset_next = next_off - ONE_OFF;
                prior_load  = 1'b1;
            end
            else
            begin
                offset_next = next_off;
            end
        end
        else if (cmd.emit_hold)
        begin
            if (next_ge_one)
            begin
                offset_next     = '0;
                have_prior_next = 1'b0;
            end
            else
            begin
                offset_next = next_off;
            end
        end
        else if (cmd.clear)
        begin
            offset_next     = '0;
            have_prior_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_reg      <= RATIO_RESET;
            chan_reg       <= CHAN_RESET;
            offset_reg     <= '0;
            have_prior_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_RATIO:    ratio_reg <= cfg_data[RATIO_W-1:0];
                    REG_CHANNELS: chan_reg  <= cfg_data[CHAN_W-1:0];
                    default:      ;
                endcase
            end
            offset_reg     <= offset_next;
            have_prior_reg <= have_prior_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cur_l_reg <= left_sample;
            cur_r_reg <= right_sample;
            end_reg   <= end_of_clip;
        end
        if (prior_load)
        begin
            prior_l_reg <= cur_l_reg;
            prior_r_reg <= cur_r_reg;
        end
        if (cmd.mul)
        begin
            prod_l_reg <= PROD_W'(diff_l) * PROD_W'(frac_s);
            prod_r_reg <= PROD_W'(diff_r) * PROD_W'(frac_s);
        end
        if (emit)
        begin
            left_out_reg  <= word_l;
            right_out_reg <= mono ? '0 : word_r;
            run_last_reg  <= word_last;
            clip_done_reg <= word_done;
        end
    end

    assign out_valid = out_valid_reg;
    assign left_out  = left_out_reg;
    assign right_out = right_out_reg;
    assign run_last  = run_last_reg;
    assign clip_done = clip_done_reg;

`ifndef SYNTHESIS
    a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> slot_free)
        else $error("word emitted while output register is occupied");

    a_emit_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (offset_reg < ONE_OFF))
        else $error("word emitted at a position beyond the current frame");

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && clip_done_reg) |-> run_last_reg)
        else $error("clip end word not marked as last of run");

    a_clip_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_hold && next_ge_one) |=> (!have_prior_reg && (offset_reg == '0)))
        else $error("clip state not cleared after final word");
`endif

endmodule

`default_nettype wire

@@ hdl/linear_interp_resampler_unit.sv @@
// linear interpolation resampler, top level: controller plus datapath
// an accepted frame goes to start, then to multiply and emit for each interpolated word
// each interpolated word: multiply, then add; held end words need no multiply
// a frame goes through accept, start and tail plus its words; the next frame is taken
// once its run is issued
// reset: clip state cleared, ratio 1.0, stereo; no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module linear_interp_resampler_unit #(
    parameter int SAMPLE_BITS = 24,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write,
    input  wire logic [lir_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [lir_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic signed [SAMPLE_BITS-1:0]     left_sample,
    input  wire logic signed [SAMPLE_BITS-1:0]     right_sample,
    input  wire logic                              end_of_clip,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic signed [SAMPLE_BITS-1:0]          left_out,
    output logic signed [SAMPLE_BITS-1:0]          right_out,
    output logic                                   run_last,
    output logic                                   clip_done
);
    import lir_pkg::*;

    lir_cmd_t cmd;
    lir_sts_t sts;

    lir_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lir_dp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .left_sample  (left_sample),
        .right_sample (right_sample),
        .end_of_clip  (end_of_clip),
        .cmd          (cmd),
        .sts          (sts),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .left_out     (left_out),
        .right_out    (right_out),
        .run_last     (run_last),
        .clip_done    (clip_done)
    );

endmodule

`default_nettype wire

@@ tb/tb_linear_interp_resampler_unit.sv @@
// self-checking testbench for linear_interp_resampler_unit: clocked driver and monitor,
// a cycle-free predictor of the interpolated words, directed clips then random clips
// depends on hdl/lir_pkg.sv and hdl/linear_interp_resampler_unit.sv
`timescale 1ns / 1ps

module tb_linear_interp_resampler_unit;
    import lir_pkg::*;

    localparam int          SBITS      = 24;
    localparam logic [31:0] UNIT_POS   = 32'h0001_0000;
    localparam logic [31:0] MIN_STRIDE = 32'd2048;
    localparam int          RUN_CAP    = 64;
    localparam int          PHASE_LEN  = 50;
    localparam logic signed [SBITS-1:0] S_MAX = 24'sh7FFFFF;
    localparam logic signed [SBITS-1:0] S_MIN = 24'sh800000;

    typedef struct packed {
        logic signed [SBITS-1:0] left;
        logic signed [SBITS-1:0] right;
        logic                    eoc;
    } src_frame_t;

    typedef struct packed {
        logic signed [SBITS-1:0] left;
        logic signed [SBITS-1:0] right;
        logic                    last;
        logic                    done;
    } out_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [SBITS-1:0] left_sample = '0;
    logic signed [SBITS-1:0] right_sample = '0;
    logic end_of_clip = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [SBITS-1:0] left_out;
    logic signed [SBITS-1:0] right_out;
    logic run_last;
    logic clip_done;

    // register mirror
    logic [RATIO_W-1:0] ratio_cfg = 24'd65536;
    logic [CHAN_W-1:0]  chan_cfg  = CHAN_RESET;

    // clip state of the predictor
    logic signed [SBITS-1:0] prev_left = '0;
    logic signed [SBITS-1:0] prev_right = '0;
    logic                    have_prev = 1'b0;
    logic [31:0]             frame_pos = '0;

    src_frame_t source_frames[$];
    out_word_t  pending_words[$];
    int frames_queued = 0;
    int frames_taken = 0;
    int mismatch_count = 0;
    int in_gap = 0;
    int in_gap_max = 0;
    int out_hold = 0;
    int out_stall_max = 0;

    linear_interp_resampler_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .left_sample  (left_sample),
        .right_sample (right_sample),
        .end_of_clip  (end_of_clip),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .left_out     (left_out),
        .right_out    (right_out),
        .run_last     (run_last),
        .clip_done    (clip_done)
    );

    always #4 clk = ~clk;

    task automatic flag_mismatch(input string what);
        mismatch_count++;
        $display("%0t mismatch: %s", $realtime, what);
    endtask

    // a + ((b - a) * frac) >>> 16, floor on the product
    function automatic logic signed [SBITS-1:0] interp(input logic signed [SBITS-1:0] a,
                                                       input logic signed [SBITS-1:0] b,
                                                       input logic [31:0] frac);
        longint diff;
        longint prod;
        diff = longint'(b) - longint'(a);
        prod = diff * longint'(frac);
        return SBITS'(longint'(a) + (prod >>> 16));
    endfunction

    // words caused by one source frame, appended to pending_words
    task automatic resample_frame(input src_frame_t f);
        out_word_t   run [RUN_CAP];
        int          n;
        logic        mono;
        logic [31:0] stride;
        n = 0;
        mono = (chan_cfg == CHAN_MONO);
        stride = (ratio_cfg < MIN_STRIDE) ? MIN_STRIDE : 32'(ratio_cfg);
        if (have_prev) begin
            while (frame_pos < UNIT_POS && n < RUN_CAP) begin
                run[n].left = interp(prev_left, f.left, frame_pos);
                run[n].right = mono ? '0 : interp(prev_right, f.right, frame_pos);
                run[n].last = 1'b0;
                run[n].done = 1'b0;
                n++;
                frame_pos += stride;
            end
            frame_pos -= UNIT_POS;
        end
        else begin
            frame_pos = '0;
            have_prev = 1'b1;
        end
        prev_left = f.left;
        prev_right = f.right;
        if (f.eoc) begin
            // positions at or past the end frame repeat it
            while (frame_pos < UNIT_POS && n < RUN_CAP) begin
                run[n].left = f.left;
                run[n].right = mono ? '0 : f.right;
                run[n].last = 1'b0;
                run[n].done = 1'b0;
                n++;
                frame_pos += stride;
            end
            if (n > 0)
                run[n-1].done = 1'b1;
            prev_left = '0;
            prev_right = '0;
            have_prev = 1'b0;
            frame_pos = '0;
        end
        if (n > 0)
            run[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
            pending_words.push_back(run[i]);
    endtask

    // driver: one frame word at a time from source_frames
    always @(posedge clk or negedge rst_n)
    begin
        src_frame_t took;
        src_frame_t nxt;
        logic       v;
        int         g;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_gap <= 0;
        end
        else
        begin
            v = in_valid;
            g = in_gap;
            if (in_valid && in_ready)
            begin
                took.left = left_sample;
                took.right = right_sample;
                took.eoc = end_of_clip;
                resample_frame(took);
                frames_taken++;
                v = 1'b0;
                g = $urandom_range(0, in_gap_max);
            end
            if (!v)
            begin
                if (g > 0)
                    g--;
                else if (source_frames.size() > 0)
                begin
                    nxt = source_frames.pop_front();
                    left_sample <= nxt.left;
                    right_sample <= nxt.right;
                    end_of_clip <= nxt.eoc;
                    v = 1'b1;
                end
            end
            in_valid <= v;
            in_gap <= g;
        end
    end

    // monitor: random back-pressure, checks each word against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        out_word_t want;
        logic      r;
        int        h;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_hold <= 0;
        end
        else
        begin
            r = out_ready;
            h = out_hold;
            if (out_valid && out_ready)
            begin
                if (pending_words.size() == 0)
                    flag_mismatch($sformatf("word l=%0d r=%0d with nothing expected",
                                            left_out, right_out));
                else
                begin
                    want = pending_words.pop_front();
                    if (left_out !== want.left)
                        flag_mismatch($sformatf("left_out %0d, expected %0d",
                                                left_out, want.left));
                    if (right_out !== want.right)
                        flag_mismatch($sformatf("right_out %0d, expected %0d",
                                                right_out, want.right));
                    if (run_last !== want.last)
                        flag_mismatch($sformatf("run_last %b, expected %b",
                                                run_last, want.last));
                    if (clip_done !== want.done)
                        flag_mismatch($sformatf("clip_done %b, expected %b",
                                                clip_done, want.done));
                end
                r = 1'b0;
                h = $urandom_range(0, out_stall_max);
            end
            if (!r)
            begin
                if (h > 0)
                    h--;
                else
                    r = 1'b1;
            end
            out_ready <= r;
            out_hold <= h;
        end
    end

    task automatic queue_frame(input logic signed [SBITS-1:0] l,
                               input logic signed [SBITS-1:0] r,
                               input logic e);
        src_frame_t f;
        f.left = l;
        f.right = r;
        f.eoc = e;
        source_frames.push_back(f);
        frames_queued++;
    endtask

    // only called while the block is idle
    task automatic set_config(input logic [CFG_DATA_W-1:0] ratio_word,
                              input logic [CFG_DATA_W-1:0] chan_word);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= REG_RATIO;
        cfg_data <= ratio_word;
        ratio_cfg = ratio_word[RATIO_W-1:0];
        @(posedge clk);
        cfg_index <= REG_CHANNELS;
        cfg_data <= chan_word;
        chan_cfg = chan_word[CHAN_W-1:0];
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // wait for every frame taken and every word seen, then let the pipeline drain
    task automatic settle();
        while (frames_taken != frames_queued)
            @(posedge clk);
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    function automatic logic signed [SBITS-1:0] pick_sample();
        logic [31:0] bits;
        bits = $urandom;
        case ($urandom_range(0, 9))
            0: return S_MAX;
            1: return S_MIN;
            2: return '0;
            3: return -24'sd1;
            default: return bits[SBITS-1:0];
        endcase
    endfunction

    initial
    begin
        logic [CFG_DATA_W-1:0] ratio_w;
        logic [CFG_DATA_W-1:0] chan_w;
        logic [31:0]           upper;
        int                    n;
        int                    len;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: unit ratio, stereo
        in_gap_max = 0;
        out_stall_max = 0;
        queue_frame(S_MAX, S_MIN, 1'b1);
        queue_frame(S_MIN, S_MAX, 1'b0);
        queue_frame(S_MAX, S_MIN, 1'b0);
        queue_frame(24'sd0, -24'sd1, 1'b1);
        settle();

        // half-step upsampling, mono, full-scale swings
        in_gap_max = 6;
        out_stall_max = 6;
        set_config(24'h008000, 24'd1);
        queue_frame(S_MIN, S_MAX, 1'b0);
        queue_frame(S_MAX, S_MIN, 1'b0);
        queue_frame(-24'sd1, 24'sd5, 1'b1);
        settle();

        // zero ratio falls back to the 1/32 floor; code 3 means stereo
        set_config(24'd0, 24'd3);
        queue_frame(S_MAX, S_MIN, 1'b0);
        queue_frame(S_MIN, S_MAX, 1'b1);
        settle();

        // just below the floor, single-frame clip, code 0 means stereo
        set_config(24'd2047, 24'd0);
        queue_frame(24'sd1234567, -24'sd7654321, 1'b1);
        settle();

        // downsampling by 1.5: some frames give no word
        set_config(24'h018000, 24'd2);
        for (int i = 0; i < 5; i++)
            queue_frame(pick_sample(), pick_sample(), i == 4);
        settle();

        // largest ratio, upper data bits set on the channel write
        set_config(24'hFFFFFF, 24'hFFFFFD);
        queue_frame(S_MAX, S_MAX, 1'b0);
        queue_frame(S_MIN, S_MIN, 1'b0);
        queue_frame(24'sd77, -24'sd77, 1'b1);
        queue_frame(S_MIN, S_MAX, 1'b1);
        settle();

        // end frame with no word of its own, then a clip left open
        set_config(24'h020000, 24'd2);
        queue_frame(24'sd100, -24'sd100, 1'b0);
        queue_frame(24'sd300, -24'sd300, 1'b1);
        queue_frame(S_MAX, S_MIN, 1'b0);
        queue_frame(24'sd0, 24'sd0, 1'b0);
        settle();

        // ratio and channel count changed in the middle of that clip
        set_config(24'h004000, 24'd1);
        queue_frame(S_MIN, S_MAX, 1'b1);
        settle();

        // random clips over random settings; a clip may run across a phase boundary
        for (int ph = 0; ph < 9; ph++)
        begin
            case ($urandom_range(0, 5))
                0: ratio_w = CFG_DATA_W'($urandom_range(2048, 65535));
                1: ratio_w = CFG_DATA_W'($urandom_range(65536, 262144));
                2: ratio_w = CFG_DATA_W'($urandom_range(0, 2047));
                3: ratio_w = $urandom_range(0, 1) ? 24'hFFFFFF
                           : CFG_DATA_W'($urandom_range(262144, 24'hFFFFFF));
                default: ratio_w = CFG_DATA_W'($urandom_range(16384, 131072));
            endcase
            upper = $urandom;
            chan_w = {($urandom_range(0, 1) ? upper[CFG_DATA_W-CHAN_W-1:0] : 22'd0),
                      CHAN_W'($urandom_range(0, 3))};
            set_config(ratio_w, chan_w);
            if (ph % 3 == 0)
            begin
                in_gap_max = 0;
                out_stall_max = 0;
            end
            else
            begin
                in_gap_max = $urandom_range(0, 1) ? 6 : 0;
                out_stall_max = $urandom_range(0, 1) ? 6 : 0;
            end
            n = 0;
            while (n < PHASE_LEN)
            begin
                len = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 12);
                for (int j = 0; j < len && n < PHASE_LEN; j++)
                begin
                    queue_frame(pick_sample(), pick_sample(), j == len - 1);
                    n++;
                end
            end
            settle();
        end

        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/lir_pkg.sv
hdl/lir_ctrl.sv
hdl/lir_dp.sv
hdl/linear_interp_resampler_unit.sv
tb/tb_linear_interp_resampler_unit.sv
